// ===== rtl/core/hhil_pkg.sv =====
// Types, constants and per-byte step functions for the HTTP header integer field lookup.
// No dependencies; used by the channel interfaces and every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package hhil_pkg;

    localparam int MAX_KEY_CHARS_DEF = 16;
    localparam int KEY_W             = 64;
    localparam int KEY_LEN_W         = 5;
    localparam int NAME_IDX_W        = 5;
    localparam int VALUE_W           = 32;
    localparam int CFG_IDX_W         = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    localparam logic [VALUE_W-1:0] ACCUM_LIMIT = 32'd429496729;

    typedef enum logic [1:0] {
        PH_NAME  = 2'd0,
        PH_VALUE = 2'd1,
        PH_SKIP  = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t                  line_phase;
        logic [NAME_IDX_W-1:0]   name_index;
        logic                    name_matching;
        logic                    cr_pending;
        logic                    field_locked;
        logic [VALUE_W-1:0]      value_accum;
        logic                    digit_seen;
        logic                    trailing_space_seen;
        logic                    value_bad;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        line_phase:          PH_NAME,
        name_index:          '0,
        name_matching:       1'b1,
        cr_pending:          1'b0,
        field_locked:        1'b0,
        value_accum:         '0,
        digit_seen:          1'b0,
        trailing_space_seen: 1'b0,
        value_bad:           1'b0
    };

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_DELTA : c;
    endfunction

    function automatic scan_state_t text_byte(
        input scan_state_t           s_in,
        input logic [7:0]            c,
        input logic [KEY_LEN_W-1:0]  klen,
        input logic [2*KEY_W-1:0]    key
    );
        scan_state_t        s;
        logic [7:0]         kc;
        logic [VALUE_W-1:0] d;
        s  = s_in;
        kc = key[s_in.name_index[3:0]*8 +: 8];
        d  = VALUE_W'(c - CH_ZERO);
        if (s.field_locked && s.line_phase != PH_VALUE) begin
            return s;
        end
        if (s.line_phase == PH_NAME) begin
            if (c == CH_COLON) begin
                if (s.name_matching && s.name_index == klen) begin
                    s.field_locked        = 1'b1;
                    s.line_phase          = PH_VALUE;
                    s.value_accum         = '0;
                    s.digit_seen          = 1'b0;
                    s.trailing_space_seen = 1'b0;
                    s.value_bad           = 1'b0;
                end
                else begin
                    s.line_phase = PH_SKIP;
                end
            end
            else if (s.name_index < klen && fold(c) == fold(kc)) begin
                s.name_index = s.name_index + 1'b1;
            end
            else begin
                s.name_matching = 1'b0;
            end
        end
        else if (s.line_phase == PH_VALUE) begin
            if (c == CH_SPACE || c == CH_TAB) begin
                if (s.digit_seen) begin
                    s.trailing_space_seen = 1'b1;
                end
            end
            else begin
                if (s.trailing_space_seen || c < CH_ZERO || c > CH_NINE) begin
                    s.value_bad = 1'b1;
                end
                else if (s.value_accum > ACCUM_LIMIT ||
                         (s.value_accum == ACCUM_LIMIT && d > 32'd5)) begin
                    s.value_bad = 1'b1;
                end
                else begin
                    s.value_accum = {s.value_accum[VALUE_W-4:0], 3'b000}
                                  + {s.value_accum[VALUE_W-2:0], 1'b0} + d;
                end
                s.digit_seen = 1'b1;
            end
        end
        return s;
    endfunction

    function automatic scan_state_t line_end(input scan_state_t s_in);
        scan_state_t s;
        s = s_in;
        if (s.line_phase == PH_VALUE) begin
            if (!s.digit_seen) begin
                s.value_bad = 1'b1;
            end
            if (s.value_bad) begin
                s.value_accum = '0;
            end
            s.line_phase = PH_SKIP;
        end
        else if (!s.field_locked) begin
            s.line_phase    = PH_NAME;
            s.name_index    = '0;
            s.name_matching = 1'b1;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hhil_if.sv =====
// Valid/ready channel interfaces: header bytes, lookup results, register writes.
// Depends on hhil_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface hhil_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hhil_result_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [hhil_pkg::VALUE_W-1:0] field_value;
    logic                         malformed;
    modport source (output valid, output found, output field_value, output malformed,
                    input ready);
    modport sink   (input valid, input found, input field_value, input malformed,
                    output ready);
endinterface

interface hhil_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [hhil_pkg::CFG_IDX_W-1:0] index;
    logic [hhil_pkg::KEY_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/hhil_in_stage.sv =====
// Input register for header bytes; releases a byte when the parser advances.
// Depends on hhil_pkg and hhil_byte_if.
`timescale 1ns / 1ps
`default_nettype none
module hhil_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    hhil_byte_if.sink              hdr,
    input  wire logic              advance,
    output hhil_pkg::byte_item_t   item
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       take;

    assign hdr.ready = !valid_reg || advance;
    assign take      = hdr.valid && hdr.ready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= hdr.data_byte;
            last_reg <= hdr.last_byte;
        end
    end

    assign item.valid     = valid_reg;
    assign item.data_byte = data_reg;
    assign item.last_byte = last_reg;

endmodule
`default_nettype wire

// ===== rtl/core/hhil_parser.sv =====
// Scan state and result register; one registered byte per cycle while the result is not stalled, CR LF framing.
// Depends on hhil_pkg and hhil_result_if.
`timescale 1ns / 1ps
`default_nettype none
module hhil_parser (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire hhil_pkg::byte_item_t              item,
    input  wire logic [hhil_pkg::KEY_LEN_W-1:0]    klen,
    input  wire logic [2*hhil_pkg::KEY_W-1:0]      key,
    output logic                                   advance,
    hhil_result_if.source                          res
);

    hhil_pkg::scan_state_t          state_reg, state_next;
    hhil_pkg::scan_state_t          s;
    logic                           out_valid_reg, out_valid_next;
    logic                           found_reg, found_next;
    logic [hhil_pkg::VALUE_W-1:0]   value_reg, value_next;
    logic                           bad_reg, bad_next;
    logic                           step;

    assign advance = !out_valid_reg || res.ready;
    assign step    = advance && item.valid;

    always_comb
    begin
        s = state_reg;
        if (s.cr_pending)
        begin
            s.cr_pending = 1'b0;
            if (item.data_byte == hhil_pkg::CH_LF)
            begin
                s = hhil_pkg::line_end(s);
            end
            else
            begin
                s = hhil_pkg::text_byte(s, hhil_pkg::CH_CR, klen, key);
                if (item.data_byte == hhil_pkg::CH_CR)
                begin
                    s.cr_pending = 1'b1;
                end
                else
                begin
                    s = hhil_pkg::text_byte(s, item.data_byte, klen, key);
                end
            end
        end
        else if (item.data_byte == hhil_pkg::CH_CR)
        begin
            s.cr_pending = 1'b1;
        end
        else
        begin
            s = hhil_pkg::text_byte(s, item.data_byte, klen, key);
        end

        if (item.last_byte)
        begin
            if (s.cr_pending)
            begin
                s.cr_pending = 1'b0;
                s = hhil_pkg::text_byte(s, hhil_pkg::CH_CR, klen, key);
            end
            s = hhil_pkg::line_end(s);
        end

        found_next     = found_reg;
        value_next     = value_reg;
        bad_next       = bad_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !res.ready;
        if (step)
        begin
            out_valid_next = item.last_byte;
            if (item.last_byte)
            begin
                found_next = s.field_locked;
                value_next = s.field_locked ? s.value_accum : '0;
                bad_next   = s.field_locked && s.value_bad;
                state_next = hhil_pkg::SCAN_RESET;
            end
            else
            begin
                state_next = s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hhil_pkg::SCAN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        value_reg <= value_next;
        bad_reg   <= bad_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.found       = found_reg;
    assign res.field_value = value_reg;
    assign res.malformed   = bad_reg;

endmodule
`default_nettype wire

// ===== rtl/core/http_header_int_field_lookup_unit.sv =====
// Top level of the HTTP header integer field lookup: keyword registers and the two stages.
// Depends on hhil_pkg, hhil_if, hhil_in_stage and hhil_parser.
//
//   channel  role    payload                                transfer at
//   hdr      sink    data_byte[7:0], last_byte              valid & ready
//   res      source  found, field_value[31:0], malformed    valid & ready, one per header
//   cfg      sink    index[1:0], data[63:0]                 valid & ready (ready held high)
//
// One byte per cycle while the result is not stalled; a last byte passes the input, then the result register.
// The step for each byte is one pass of logic between the input and result registers.
// A stalled result holds the parser, which backs up into the input register, then hdr.
// Reset clears scan state and keywords (length 1); state also clears after every header.
`timescale 1ns / 1ps
`default_nettype none
module http_header_int_field_lookup_unit #(
    parameter int MAX_KEY_CHARS = hhil_pkg::MAX_KEY_CHARS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    hhil_byte_if.sink      hdr,
    hhil_result_if.source  res,
    hhil_cfg_if.sink       cfg
);

    logic [hhil_pkg::KEY_W-1:0]     key_low_reg;
    logic [hhil_pkg::KEY_W-1:0]     key_high_reg;
    logic [hhil_pkg::KEY_LEN_W-1:0] key_len_reg;
    logic [hhil_pkg::KEY_LEN_W-1:0] klen;
    logic                           advance;
    hhil_pkg::byte_item_t           item;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= hhil_pkg::KEY_LEN_W'(1);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                hhil_pkg::CFG_KEY_LOW:  key_low_reg  <= cfg.data;
                hhil_pkg::CFG_KEY_HIGH: key_high_reg <= cfg.data;
                hhil_pkg::CFG_KEY_LEN:  key_len_reg  <= cfg.data[hhil_pkg::KEY_LEN_W-1:0];
                default:                ;
            endcase
        end
    end

    assign klen = (key_len_reg > hhil_pkg::KEY_LEN_W'(MAX_KEY_CHARS))
                ? hhil_pkg::KEY_LEN_W'(MAX_KEY_CHARS) : key_len_reg;

    hhil_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .hdr     (hdr),
        .advance (advance),
        .item    (item)
    );

    hhil_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .klen    (klen),
        .key     ({key_high_reg, key_low_reg}),
        .advance (advance),
        .res     (res)
    );

endmodule
`default_nettype wire
